/* rtl/clws_pkg.sv */
// clws_pkg: shared types, constants and lookup functions for the character LCD
// write sequencer; used by every module in rtl, has no dependencies
`default_nettype none

package clws_pkg;

  localparam int GLYPH_ROWS = 8;
  localparam int STEP_W = 4;
  localparam int INIT8_LEN = 3;
  localparam int INIT4_LEN = 7;
  localparam int NUM_DIGITS = 5;

  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_BYTE   = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_CURSOR = 3'd3;
  localparam logic [2:0] CMD_NUMBER = 3'd4;
  localparam logic [2:0] CMD_GLYPH  = 3'd5;

  localparam logic [10:0] EN_HIGH_US     = 11'd2000;
  localparam logic [15:0] LEAD_US        = 16'd45000;
  localparam logic [10:0] NIB_CMD_GAP_US = 11'd200;
  localparam logic [10:0] BYTE_DONE_US   = 11'd2000;

  localparam logic [2:0] LAST_POS = 3'(NUM_DIGITS - 1);

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  byte_value;
    logic [15:0] number;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [2:0]  glyph_slot;
    logic [63:0] glyph_rows;
  } req_t;

  typedef struct packed {
    logic        reg_select;
    logic [7:0]  bus_byte;
    logic [10:0] enable_high_us;
    logic [15:0] lead_delay_us;
    logic [10:0] wait_after_us;
    logic        last;
  } strobe_t;

  // one byte handed from the sequencer to the strobe unit
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       lead;
    logic       last;
  } byte_t;

  typedef struct packed {
    logic [3:0] value;
    logic       last;
    logic       skip;
  } digit_t;

  function automatic logic [7:0] init8_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h38;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] init4_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h03;
      3'd1:    b = 8'h02;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h08;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      3'd6:    b = 8'h0C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] pos);
    logic [13:0] p;
    unique case (pos)
      3'd0:    p = 14'd10000;
      3'd1:    p = 14'd1000;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd10;
      3'd4:    p = 14'd1;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* rtl/clws_digit_unit.sv */
// clws_digit_unit: decimal digit extraction, most significant first, by repeated
// compare and subtract of powers of ten; depends on clws_pkg
`default_nettype none

module clws_digit_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [15:0]   value,
  input  wire logic          take,
  output logic               busy,
  output logic               present,
  output clws_pkg::digit_t   digit
);

  logic [15:0] rem;
  logic [2:0]  pos;
  logic [3:0]  count;
  logic        started;
  logic [13:0] pow;
  logic        fits;
  logic        at_last;

  assign pow     = clws_pkg::pow10(pos);
  assign fits    = rem >= {2'b00, pow};
  assign at_last = pos == clws_pkg::LAST_POS;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      present <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      present <= 1'b0;
      rem     <= value;
      pos     <= 3'd0;
      count   <= 4'd0;
      started <= 1'b0;
    end else if (busy) begin
      if (present) begin
        if (take) begin
          started <= started | (count != 4'd0);
          count   <= 4'd0;
          present <= 1'b0;
          if (at_last) begin
            busy <= 1'b0;
          end else begin
            pos <= pos + 3'd1;
          end
        end
      end else if (fits) begin
        rem   <= rem - {2'b00, pow};
        count <= count + 4'd1;
      end else begin
        present <= 1'b1;
      end
    end
  end

  assign digit.value = count;
  assign digit.last  = at_last;
  assign digit.skip  = !started && (count == 4'd0) && !at_last;

endmodule

`default_nettype wire

/* rtl/clws_strobe_unit.sv */
// clws_strobe_unit: splits one byte into one or two enable strobes and holds them
// in an output register; depends on clws_pkg
`default_nettype none

module clws_strobe_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              bus_8bit,
  input  wire logic              byte_valid,
  output logic                   byte_ready,
  input  wire clws_pkg::byte_t   byte_in,
  output logic                   strobe_valid,
  input  wire logic              strobe_ready,
  output clws_pkg::strobe_t      strobe
);

  logic              held;
  logic              low_half;
  clws_pkg::byte_t   cur;
  clws_pkg::strobe_t strobe_next;
  logic              adv;

  assign byte_ready = !held;
  assign adv        = held && (!strobe_valid || strobe_ready);

  always_comb begin
    strobe_next.reg_select     = cur.rs;
    strobe_next.enable_high_us = clws_pkg::EN_HIGH_US;
    strobe_next.lead_delay_us  = (cur.lead && !low_half) ? clws_pkg::LEAD_US : 16'd0;
    strobe_next.last           = cur.last && (bus_8bit || low_half);
    if (bus_8bit) begin
      strobe_next.bus_byte      = cur.value;
      strobe_next.wait_after_us = 11'd0;
    end else if (low_half) begin
      strobe_next.bus_byte      = {cur.value[3:0], 4'h0};
      strobe_next.wait_after_us = clws_pkg::BYTE_DONE_US;
    end else begin
      strobe_next.bus_byte      = {cur.value[7:4], 4'h0};
      strobe_next.wait_after_us = cur.rs ? 11'd0 : clws_pkg::NIB_CMD_GAP_US;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= 1'b0;
      strobe_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        held     <= 1'b1;
        cur      <= byte_in;
        low_half <= 1'b0;
      end
      if (adv) begin
        strobe_valid <= 1'b1;
        strobe       <= strobe_next;
        if (bus_8bit || low_half) begin
          held <= 1'b0;
        end else begin
          low_half <= 1'b1;
        end
      end else if (strobe_ready) begin
        strobe_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/char_lcd_write_sequencer_core.sv */
// char_lcd_write_sequencer_core: request sequencer for a character LCD, top level
// depends on clws_pkg, clws_digit_unit and clws_strobe_unit
//
// usage:
//  req channel (req_valid/req_ready/req) takes one request word: init, command
//  byte, data byte, cursor move, decimal number or custom glyph
//  strobe channel (strobe_valid/strobe_ready/strobe) gives one word per enable
//  strobe, last set on the final strobe of a request; codes 6 and 7 give none
//  cfg channel (cfg_valid/cfg_ready/cfg_data) writes the bus width bit, always ready
//  the first strobe word passes the request register, the strobe unit's byte
//  register and its output register, later for a number while its leading
//  digits are worked out; the strobe unit takes one byte at a time and takes
//  no new byte until it has given the last strobe of the one it holds; a number
//  works its digits out in turn in the shared compare and subtract unit
//  req_ready is high only while the sequencer is idle; it rises once the last
//  byte is handed to the strobe unit, which may still be emitting
//  a stalled strobe word holds in the output register and backs up the sequencer
//  reset: bus width returns to 4-bit, sequencer and strobe unit go idle
`default_nettype none

module char_lcd_write_sequencer_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire clws_pkg::req_t     req,
  output logic                    strobe_valid,
  input  wire logic               strobe_ready,
  output clws_pkg::strobe_t       strobe,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INIT   = 3'd1;
  localparam logic [2:0] ST_SINGLE = 3'd2;
  localparam logic [2:0] ST_NUM    = 3'd3;
  localparam logic [2:0] ST_GLYPH  = 3'd4;

  logic                          bus_8bit;
  logic [2:0]                    state;
  logic [clws_pkg::STEP_W-1:0]   step;
  clws_pkg::req_t                req_r;
  clws_pkg::byte_t               byte_out;
  logic                          byte_valid;
  logic                          byte_ready;
  logic                          byte_fire;
  logic                          dig_busy;
  logic                          dig_present;
  logic                          dig_take;
  clws_pkg::digit_t              dig;
  logic [3:0]                    col_c;
  logic [7:0]                    cursor_byte;
  logic [2:0]                    row_idx;
  logic [7:0]                    row_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_8bit <= 1'b0;
    end else if (cfg_valid) begin
      bus_8bit <= cfg_data;
    end
  end

  assign req_ready = state == ST_IDLE;

  assign col_c       = (|req_r.column[7:4]) ? 4'hF : req_r.column[3:0];
  assign cursor_byte = {1'b1, |req_r.row, 2'b00, col_c};
  assign row_idx     = step[2:0] - 3'd1;
  assign row_byte    = req_r.glyph_rows[{row_idx, 3'b000} +: 8];

  always_comb begin
    byte_valid = 1'b0;
    byte_out   = '0;
    dig_take   = 1'b0;
    unique case (state)
      ST_INIT: begin
        byte_valid    = 1'b1;
        byte_out.lead = step == '0;
        if (bus_8bit) begin
          byte_out.value = clws_pkg::init8_byte(step[1:0]);
          byte_out.last  = step == clws_pkg::STEP_W'(clws_pkg::INIT8_LEN - 1);
        end else begin
          byte_out.value = clws_pkg::init4_byte(step[2:0]);
          byte_out.last  = step == clws_pkg::STEP_W'(clws_pkg::INIT4_LEN - 1);
        end
      end
      ST_SINGLE: begin
        byte_valid     = 1'b1;
        byte_out.rs    = req_r.cmd == clws_pkg::CMD_DATA;
        byte_out.value = (req_r.cmd == clws_pkg::CMD_CURSOR) ? cursor_byte : req_r.byte_value;
        byte_out.last  = 1'b1;
      end
      ST_NUM: begin
        byte_valid     = dig_present && !dig.skip;
        byte_out.rs    = 1'b1;
        byte_out.value = {4'h3, dig.value};
        byte_out.last  = dig.last;
        dig_take       = dig_present && (dig.skip || byte_ready);
      end
      ST_GLYPH: begin
        byte_valid = 1'b1;
        priority if (step == '0) begin
          byte_out.value = {2'b01, req_r.glyph_slot, 3'b000};
        end else if (step <= clws_pkg::STEP_W'(clws_pkg::GLYPH_ROWS)) begin
          byte_out.rs    = 1'b1;
          byte_out.value = row_byte;
        end else if (step == clws_pkg::STEP_W'(clws_pkg::GLYPH_ROWS + 1)) begin
          byte_out.value = cursor_byte;
        end else begin
          byte_out.rs    = 1'b1;
          byte_out.value = {5'b00000, req_r.glyph_slot};
          byte_out.last  = 1'b1;
        end
      end
      default: begin
        byte_valid = 1'b0;
      end
    endcase
  end

  assign byte_fire = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (state == ST_IDLE) begin
      if (req_valid) begin
        unique case (req.cmd)
          clws_pkg::CMD_INIT:   state <= ST_INIT;
          clws_pkg::CMD_BYTE:   state <= ST_SINGLE;
          clws_pkg::CMD_DATA:   state <= ST_SINGLE;
          clws_pkg::CMD_CURSOR: state <= ST_SINGLE;
          clws_pkg::CMD_NUMBER: state <= ST_NUM;
          clws_pkg::CMD_GLYPH:  state <= ST_GLYPH;
          default:              state <= ST_IDLE;
        endcase
      end
    end else if (byte_fire && byte_out.last) begin
      state <= ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_r <= req;
      step  <= '0;
    end else if (byte_fire) begin
      step <= step + 1'b1;
    end
  end

  clws_digit_unit u_digit (
    .clk     (clk),
    .rst     (rst),
    .start   (req_valid && req_ready && (req.cmd == clws_pkg::CMD_NUMBER)),
    .value   (req.number),
    .take    (dig_take),
    .busy    (dig_busy),
    .present (dig_present),
    .digit   (dig)
  );

  clws_strobe_unit u_strobe (
    .clk          (clk),
    .rst          (rst),
    .bus_8bit     (bus_8bit),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_in      (byte_out),
    .strobe_valid (strobe_valid),
    .strobe_ready (strobe_ready),
    .strobe       (strobe)
  );

  a_idle_digit_quiet: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !dig_busy)
    else $error("digit unit busy while sequencer idle");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    dig_present |-> dig.value <= 4'd9)
    else $error("digit out of decimal range");

  a_last_ends_request: assert property (@(posedge clk) disable iff (rst)
    byte_fire && byte_out.last |=> state == ST_IDLE)
    else $error("sequencer not idle after last word");

  a_lead_on_command: assert property (@(posedge clk) disable iff (rst)
    strobe_valid && (strobe.lead_delay_us != 16'd0) |-> !strobe.reg_select)
    else $error("lead delay on a data strobe");

endmodule

`default_nettype wire
